[rtl/ipv6_lpm_pkg.sv]
package ipv6_lpm_pkg;

	localparam int DEFAULT_ENTRIES = 64;
	localparam logic [7:0] MAX_PLEN = 8'd128;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_FULL     = 2'd1;
	localparam logic [1:0] STATUS_BAD_PLEN = 2'd2;

	typedef struct packed {
		logic        cmd;
		logic [63:0] addr_hi;
		logic [63:0] addr_lo;
		logic [7:0]  plen;
		logic [15:0] site_in;
	} req_t;

	typedef struct packed {
		logic [15:0] site_out;
		logic [7:0]  match_len;
		logic        found;
		logic [1:0]  status;
	} rsp_t;

	typedef struct packed {
		logic [127:0] prefix;
		logic [7:0]   len;
		logic [15:0]  site;
	} entry_t;

	// Keep the top len bits of a 128-bit address; len of 128 or more keeps all.
	function automatic logic [127:0] prefix_mask(input logic [7:0] len);
		prefix_mask = ~({128{1'b1}} >> len);
	endfunction

endpackage

[rtl/ipv6_longest_prefix_match_table_unit.sv]
// IPv6 longest-prefix-match route table, one stored entry compared per cycle.
// A request with prefix length above 128 raises done without scanning; otherwise done rises
// after the scan has compared every held entry, or sooner when an insert finds its prefix
// already held. Busy drops as done rises, so the block takes no new request while a scan is
// in progress; the receiver cannot stall.
// Reset empties the table at once by clearing the fill count; table contents are not cleared.
module ipv6_longest_prefix_match_table_unit #(
	parameter int ENTRIES = ipv6_lpm_pkg::DEFAULT_ENTRIES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  ipv6_lpm_pkg::req_t req,
	output logic               done,
	output ipv6_lpm_pkg::rsp_t result
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	// Route table: entries are never removed, so entries 0..count-1 are exactly the
	// valid ones and the lowest free slot is always count.
	ipv6_lpm_pkg::entry_t mem [ENTRIES];
	ipv6_lpm_pkg::entry_t rdata_q;

	state_t        state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_idx_q;
	logic          pend_q;
	logic [IW-1:0] pend_idx_q;
	logic          done_q;
	logic          best_hit_q;
	logic [7:0]    best_len_q;
	logic [15:0]   best_site_q;

	// Held request: address is pre-masked for an insert, raw for a lookup.
	logic          q_cmd_q;
	logic [127:0]  q_addr_q;
	logic [7:0]    q_len_q;
	logic [15:0]   q_site_q;
	ipv6_lpm_pkg::rsp_t result_q;

	logic          accept;
	logic          bad_len;
	logic          rd_en;
	logic          cmp_vld;
	logic          ins_hit;
	logic          lk_hit;
	logic          take_best;
	logic          scan_end;
	logic          full;
	logic          mem_we;
	logic [IW-1:0] mem_wa;
	logic          fin;
	ipv6_lpm_pkg::rsp_t   res_d;
	ipv6_lpm_pkg::entry_t wdata;
	logic [127:0]  req_addr;

	assign accept   = start && (state_q == ST_IDLE);
	assign bad_len  = req.plen > ipv6_lpm_pkg::MAX_PLEN;
	assign req_addr = {req.addr_hi, req.addr_lo};
	assign full     = (count_q == CW'(ENTRIES));
	assign wdata    = '{prefix: q_addr_q, len: q_len_q, site: q_site_q};

	always_comb begin
		rd_en     = (state_q == ST_SCAN) && (rd_idx_q != count_q);
		cmp_vld   = (state_q == ST_SCAN) && pend_q;
		// Insert: same length and same masked prefix means overwrite the site.
		ins_hit   = cmp_vld && (q_cmd_q == ipv6_lpm_pkg::CMD_INSERT) &&
			(rdata_q.len == q_len_q) && (rdata_q.prefix == q_addr_q);
		// Lookup: entry no longer than the query and query bits agree under its mask.
		lk_hit    = cmp_vld && (q_cmd_q == ipv6_lpm_pkg::CMD_LOOKUP) &&
			(rdata_q.len <= q_len_q) &&
			((q_addr_q & ipv6_lpm_pkg::prefix_mask(rdata_q.len)) == rdata_q.prefix);
		take_best = lk_hit && (!best_hit_q || (rdata_q.len > best_len_q));
		scan_end  = (state_q == ST_SCAN) && !pend_q && !rd_en;

		mem_we = ins_hit ||
			(scan_end && (q_cmd_q == ipv6_lpm_pkg::CMD_INSERT) && !full);
		mem_wa = ins_hit ? pend_idx_q : count_q[IW-1:0];

		fin   = 1'b0;
		res_d = '{site_out: 16'd0, match_len: 8'd0, found: 1'b0,
			status: ipv6_lpm_pkg::STATUS_OK};
		if (accept && bad_len) begin
			fin          = 1'b1;
			res_d.status = ipv6_lpm_pkg::STATUS_BAD_PLEN;
		end else if (ins_hit) begin
			fin = 1'b1;
		end else if (scan_end) begin
			fin = 1'b1;
			if (q_cmd_q == ipv6_lpm_pkg::CMD_INSERT) begin
				if (full) begin
					res_d.status = ipv6_lpm_pkg::STATUS_FULL;
				end
			end else if (best_hit_q) begin
				res_d.site_out  = best_site_q;
				res_d.match_len = best_len_q;
				res_d.found     = 1'b1;
			end
		end
	end

	// Table storage: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_idx_q[IW-1:0]];
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			rd_idx_q   <= '0;
			pend_q     <= 1'b0;
			done_q     <= 1'b0;
			best_hit_q <= 1'b0;
			best_len_q <= 8'd0;
		end else begin
			done_q <= fin;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && !bad_len) begin
						state_q    <= ST_SCAN;
						rd_idx_q   <= '0;
						pend_q     <= 1'b0;
						best_hit_q <= 1'b0;
						best_len_q <= 8'd0;
					end
				end
				ST_SCAN: begin
					pend_q <= rd_en;
					if (rd_en) begin
						rd_idx_q <= rd_idx_q + CW'(1);
					end
					if (take_best) begin
						best_hit_q <= 1'b1;
						best_len_q <= rdata_q.len;
					end
					if (ins_hit) begin
						// Drop the read in flight and finish.
						state_q <= ST_IDLE;
					end else if (scan_end) begin
						state_q <= ST_IDLE;
						if ((q_cmd_q == ipv6_lpm_pkg::CMD_INSERT) && !full) begin
							count_q <= count_q + CW'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request and result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			q_cmd_q  <= req.cmd;
			q_len_q  <= req.plen;
			q_site_q <= req.site_in;
			q_addr_q <= (req.cmd == ipv6_lpm_pkg::CMD_INSERT) ?
				(req_addr & ipv6_lpm_pkg::prefix_mask(req.plen)) : req_addr;
		end
		if (rd_en) begin
			pend_idx_q <= rd_idx_q[IW-1:0];
		end
		if (take_best) begin
			best_site_q <= rdata_q.site;
		end
		if (fin) begin
			result_q <= res_d;
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

import ipv6_lpm_pkg::*;

// Route table mirror: the held prefixes and the results they imply, oldest first
class route_scoreboard;
	logic         held[DEFAULT_ENTRIES];
	logic [127:0] held_prefix[DEFAULT_ENTRIES];
	logic [7:0]   held_len[DEFAULT_ENTRIES];
	logic [15:0]  held_site[DEFAULT_ENTRIES];
	rsp_t         routes_due[$];
	int           errors;

	function new();
		foreach (held[i]) held[i] = 1'b0;
		errors = 0;
	endfunction

	static function logic [127:0] keep_top(logic [7:0] n);
		if (n == 8'd0) return '0;
		if (n >= MAX_PLEN) return '1;
		return {128{1'b1}} << (128 - int'(n));
	endfunction

	function int outstanding();
		return routes_due.size();
	endfunction

	// Work out the result of an accepted request and update the mirrored table
	function void note_request(req_t r);
		rsp_t         x;
		logic [127:0] a;
		logic [127:0] pfx;
		int           slot;
		int           best;
		bit           hit;
		x = '0;
		x.status = STATUS_OK;
		a = {r.addr_hi, r.addr_lo};
		if (r.plen > MAX_PLEN) begin
			x.status = STATUS_BAD_PLEN;
		end else if (r.cmd == CMD_INSERT) begin
			pfx = a & keep_top(r.plen);
			slot = -1;
			hit = 1'b0;
			for (int i = 0; i < DEFAULT_ENTRIES; i++) begin
				if (held[i]) begin
					if (!hit && held_len[i] == r.plen && held_prefix[i] == pfx) begin
						held_site[i] = r.site_in;
						hit = 1'b1;
					end
				end else if (slot < 0) begin
					slot = i;
				end
			end
			if (!hit) begin
				if (slot < 0) begin
					x.status = STATUS_FULL;
				end else begin
					held[slot] = 1'b1;
					held_prefix[slot] = pfx;
					held_len[slot] = r.plen;
					held_site[slot] = r.site_in;
				end
			end
		end else begin
			best = -1;
			for (int i = 0; i < DEFAULT_ENTRIES; i++) begin
				if (held[i] && held_len[i] <= r.plen &&
				    (a & keep_top(held_len[i])) == held_prefix[i] &&
				    (best < 0 || held_len[i] > held_len[best]))
					best = i;
			end
			if (best >= 0) begin
				x.site_out = held_site[best];
				x.match_len = held_len[best];
				x.found = 1'b1;
			end
		end
		routes_due = {routes_due, x};
	endfunction

	function void report_field(string field, logic [15:0] want, logic [15:0] got);
		errors++;
		$display("%0t: %s expected %0h actual %0h", $time, field, want, got);
	endfunction

	function void check_result(rsp_t got);
		rsp_t want;
		if (routes_due.size() == 0) begin
			errors++;
			$display("%0t: result expected none actual %h", $time, got);
			return;
		end
		want = routes_due.pop_front();
		if (got.site_out !== want.site_out)
			report_field("site_out", want.site_out, got.site_out);
		if (got.match_len !== want.match_len)
			report_field("match_len", 16'(want.match_len), 16'(got.match_len));
		if (got.found !== want.found)
			report_field("found", 16'(want.found), 16'(got.found));
		if (got.status !== want.status)
			report_field("status", 16'(want.status), 16'(got.status));
	endfunction
endclass

module tb_top;
	localparam int POOL     = 96;
	localparam int N_RANDOM = 1800;
	localparam int LIMIT    = 1000000;
	localparam logic [127:0] ONES = {128{1'b1}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	req_t req = '0;
	rsp_t result;

	route_scoreboard routes;
	int              cycles = 0;

	// Route pool: prefixes grouped under a few roots so lookups hit at many depths
	logic [127:0] roots[4];
	logic [127:0] pool_addr[POOL];
	logic [7:0]   pool_len[POOL];

	logic [127:0] a;
	logic [7:0]   ql;
	int           p;
	int           kind;

	ipv6_longest_prefix_match_table_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.result(result)
	);

	always #5 clk = ~clk;

	// Check the result strobe first, then note a request taken on the same edge
	always @(posedge clk) begin
		if (done) routes.check_result(result);
		if (arst_n && start && !busy) routes.note_request(req);
	end

	// Abandon the run if it hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic logic [127:0] rand128();
		return {$urandom, $urandom, $urandom, $urandom};
	endfunction

	// Favour the boundary lengths a quarter of the time
	function automatic logic [7:0] pick_len();
		logic [7:0] corner[7] = '{8'd0, 8'd1, 8'd63, 8'd64, 8'd65, 8'd127, 8'd128};
		if ($urandom_range(0, 3) == 0) return corner[$urandom_range(0, 6)];
		return 8'($urandom_range(0, 128));
	endfunction

	function automatic req_t make_request(logic c, logic [127:0] addr, logic [7:0] n,
	                                      logic [15:0] site);
		req_t r;
		r.cmd = c;
		r.addr_hi = addr[127:64];
		r.addr_lo = addr[63:0];
		r.plen = n;
		r.site_in = site;
		return r;
	endfunction

	// Present a request and hold it until the block takes it
	task automatic issue(req_t r);
		req <= r;
		if (!start) start <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	// Drop start for a burst of idle cycles
	task automatic rest(int n);
		if (start) start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Hold off until every outstanding result has come back
	task automatic drain();
		if (start) start <= 1'b0;
		do @(posedge clk); while (routes.outstanding() != 0);
	endtask

	initial begin
		routes = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty table, bad lengths, default and host routes, overwrite,
		// masking of stray bits, query length shorter than the entry
		issue(make_request(CMD_LOOKUP, ONES, 8'd128, 16'h0000));
		issue(make_request(CMD_INSERT, ONES, 8'd129, 16'hFFFF));
		issue(make_request(CMD_LOOKUP, ONES, 8'd255, 16'hFFFF));
		issue(make_request(CMD_INSERT, ONES, 8'd0, 16'hFFFF));
		issue(make_request(CMD_LOOKUP, rand128(), 8'd0, 16'h0000));
		rest(3);
		issue(make_request(CMD_INSERT, ONES, 8'd128, 16'h0001));
		issue(make_request(CMD_LOOKUP, ONES, 8'd128, 16'h0000));
		issue(make_request(CMD_LOOKUP, ONES, 8'd127, 16'h0000));
		issue(make_request(CMD_INSERT, {64'hAAAA_AAAA_AAAA_AAAA, ~64'h0}, 8'd64, 16'h1234));
		issue(make_request(CMD_INSERT, {64'hAAAA_AAAA_AAAA_AAAA, 64'h0}, 8'd64, 16'h5678));
		issue(make_request(CMD_LOOKUP, {64'hAAAA_AAAA_AAAA_AAAA, $urandom, $urandom},
		                   8'd128, 16'h0));
		issue(make_request(CMD_INSERT, {64'hAAAA_AAAA_AAAA_AAAA, 64'h8000_0000_0000_0001},
		                   8'd65, 16'h00AA));
		issue(make_request(CMD_LOOKUP, {64'hAAAA_AAAA_AAAA_AAAA, ~64'h0}, 8'd128, 16'h0));
		issue(make_request(CMD_LOOKUP, {64'hAAAA_AAAA_AAAA_AAAA, ~64'h0}, 8'd64, 16'h0));
		issue(make_request(CMD_INSERT, {64'h8000_0000_0000_0000, 64'h0}, 8'd1, 16'h0101));
		issue(make_request(CMD_INSERT, {64'h5555_5555_5555_5555, ~64'h0}, 8'd63, 16'hBEEF));
		issue(make_request(CMD_LOOKUP, {64'h5555_5555_5555_5555, 64'h0}, 8'd200, 16'h0));
		issue(make_request(CMD_LOOKUP, {64'h5555_5555_5555_5554, 64'h0}, 8'd128, 16'h0));
		issue(make_request(CMD_INSERT, 128'h0, 8'd128, 16'h0000));
		issue(make_request(CMD_LOOKUP, 128'h0, 8'd128, 16'h0000));
		issue(make_request(CMD_LOOKUP, {64'h7FFF_FFFF_FFFF_FFFF, ~64'h0}, 8'd128, 16'h0));
		drain();

		// Build the route pool
		foreach (roots[i]) roots[i] = rand128();
		for (int i = 0; i < POOL; i++) begin
			pool_addr[i] = roots[$urandom_range(0, 3)] ^
			               (rand128() & ~routes.keep_top(pick_len()));
			pool_len[i] = pick_len();
		end

		// Random: pool inserts fill the table part way through, after which inserts of
		// unheld routes report full; lookups stay near pool routes; the rest is noise
		for (int n = 0; n < N_RANDOM; n++) begin
			kind = $urandom_range(0, 99);
			p = $urandom_range(0, POOL - 1);
			if (kind < 22) begin
				// stray bits below the prefix must be masked off
				a = pool_addr[p] ^ (rand128() & ~routes.keep_top(pool_len[p]));
				issue(make_request(CMD_INSERT, a, pool_len[p], 16'($urandom)));
			end else if (kind < 82) begin
				a = pool_addr[p] ^
				    (rand128() & ~routes.keep_top(
				        8'($urandom_range(pool_len[p], 128))));
				case ($urandom_range(0, 2))
					0: ql = 8'd128;
					1: ql = 8'($urandom_range(0, 128));
					default: ql = 8'($urandom_range(pool_len[p], 128));
				endcase
				issue(make_request(CMD_LOOKUP, a, ql, 16'($urandom)));
			end else begin
				issue(make_request($urandom_range(0, 1) ? CMD_LOOKUP : CMD_INSERT, rand128(),
				                   8'($urandom_range(0, 255)), 16'($urandom)));
			end
			// idle in bursts, leave quiet stretches, and none near the end
			if (n == N_RANDOM / 2)
				drain();
			else if (n < N_RANDOM - 300 && (n % 200) < 150 && $urandom_range(0, 3) == 0)
				rest($urandom_range(1, 8));
		end
		if (start) start <= 1'b0;

		// Wait for the last results, then allow a scan's worth of quiet cycles
		do @(posedge clk); while (routes.outstanding() != 0);
		repeat (80) @(posedge clk);
		if (routes.outstanding() != 0) begin
			routes.errors++;
			$display("%0t: results expected %0d actual 0", $time, routes.outstanding());
		end
		if (routes.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

[files.f]
rtl/ipv6_lpm_pkg.sv
rtl/ipv6_longest_prefix_match_table_unit.sv
tb/tb_top.sv
